// ----- rtl/tlqm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqm_pkg
// Shared types and constants for the link quality monitor.
// ----------------------------------------------------------------------------
package tlqm_pkg;

   localparam int DEVICE_COUNT_DEFAULT = 16;
   localparam int TYPE_SLOTS_DEFAULT   = 4;
   localparam int SLOT_MAX             = 4;

   localparam logic [2:0] REG_MASK   = 3'd0;
   localparam logic [2:0] REG_SLOT_0 = 3'd1;
   localparam logic [2:0] REG_SLOT_3 = 3'd4;

   localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
   localparam logic [13:0] RATE_SCALE = 14'd10000;

   typedef struct packed {
      logic        is_frame;
      logic [3:0]  device_index;
      logic [15:0] message_type;
      logic [31:0] sequence_number;
      logic [47:0] timestamp_ms;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] received_count;
      logic [31:0] missing_count;
      logic [31:0] out_of_order_count;
      logic [47:0] last_interval_ms;
      logic [47:0] average_interval_ms;
      logic [47:0] average_jitter_ms;
      logic [13:0] delivery_rate;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic        hit;
      logic [3:0]  dev;
      logic [31:0] seq;
      logic [47:0] now;
   } work_type;

   // Per-device record, one RAM word.
   typedef struct packed {
      logic        seq_valid;
      logic [31:0] last_seq;
      logic        time_valid;
      logic [47:0] last_time;
      logic        prior_valid;
      logic [47:0] prior_interval;
      logic [31:0] recv_total;
      logic [31:0] miss_total;
      logic [31:0] ooo_total;
      logic [63:0] interval_sum;
      logic [31:0] interval_cnt;
      logic [63:0] jitter_sum;
      logic [31:0] jitter_cnt;
      logic [47:0] held_last;
      logic [47:0] held_avg_iv;
      logic [47:0] held_avg_jt;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

// ----- rtl/tlqm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tlqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/tlqm_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqm_divider
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tlqm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/tlqm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqm_front
// Register file and classifier; pushes classified items into a short queue.
// ----------------------------------------------------------------------------
module tlqm_front #(
   parameter int DEVICE_COUNT = tlqm_pkg::DEVICE_COUNT_DEFAULT,
   parameter int TYPE_SLOTS   = tlqm_pkg::TYPE_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  tlqm_pkg::req_type    req_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 q_valid,
   input  logic                 q_pop,
   output tlqm_pkg::work_type   q_data
);
   logic [3:0]  mask_ff;
   logic [15:0] slot_ff [tlqm_pkg::SLOT_MAX];
   logic [2:0]  reg_idx;
   logic        hit;
   tlqm_pkg::work_type q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ptr_ff, wr_ptr_ff;
   logic        push_ok;

   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         for (int i = 0; i < tlqm_pkg::SLOT_MAX; i++) slot_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (reg_idx == tlqm_pkg::REG_MASK) mask_ff <= csr_pwdata[3:0];
         else if (reg_idx >= tlqm_pkg::REG_SLOT_0 && reg_idx <= tlqm_pkg::REG_SLOT_3)
            slot_ff[2'(reg_idx - tlqm_pkg::REG_SLOT_0)] <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == tlqm_pkg::REG_MASK) csr_prdata = {28'd0, mask_ff};
      else if (reg_idx >= tlqm_pkg::REG_SLOT_0 && reg_idx <= tlqm_pkg::REG_SLOT_3)
         csr_prdata = {16'd0, slot_ff[2'(reg_idx - tlqm_pkg::REG_SLOT_0)]};
   end

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < TYPE_SLOTS; i++)
         if (mask_ff[i] && slot_ff[i] == req_data.message_type) hit = 1'b1;
      if (!req_data.is_frame || 32'(req_data.device_index) >= 32'(DEVICE_COUNT)) hit = 1'b0;
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff].hit <= hit;
         q_ff[wr_ptr_ff].dev <= req_data.device_index;
         q_ff[wr_ptr_ff].seq <= req_data.sequence_number;
         q_ff[wr_ptr_ff].now <= req_data.timestamp_ms;
      end
      if (reset) begin
         cnt_ff    <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop && q_valid) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(q_pop && q_valid);
      end
   end

   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd2) |-> !push_ok)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd0) |-> !q_valid)
      else $error("empty queue shows valid");
endmodule

// ----- rtl/tlqm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlqm_back
// Per-device record update sequencer with shared divider and result buffer.
// ----------------------------------------------------------------------------
module tlqm_back #(
   parameter int DEVICE_COUNT = tlqm_pkg::DEVICE_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  tlqm_pkg::work_type q_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output tlqm_pkg::rsp_type  rsp_data
);
   // The device index field is four bits wide, so at most 16 records are
   // ever reachable.
   localparam int DEV_USED = (DEVICE_COUNT < 16) ? DEVICE_COUNT : 16;
   localparam int AW = (DEV_USED > 1) ? $clog2(DEV_USED) : 1;
   localparam int RAM_DEPTH = 1 << AW;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_UPD   = 4'd3;
   localparam logic [3:0] S_DIV1  = 4'd4;
   localparam logic [3:0] S_WAIT1 = 4'd5;
   localparam logic [3:0] S_DIV2  = 4'd6;
   localparam logic [3:0] S_WAIT2 = 4'd7;
   localparam logic [3:0] S_DIV3  = 4'd8;
   localparam logic [3:0] S_WAIT3 = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;
   localparam logic [3:0] S_HOLD  = 4'd11;
   localparam logic [3:0] S_JIT   = 4'd12;

   logic [3:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   tlqm_pkg::work_type wk_ff, wk_in;
   tlqm_pkg::rec_type  rec_ff, rec_in, rd_rec;
   logic        do_iv_ff, do_iv_in, do_jt_ff, do_jt_in;
   logic [63:0] rate_num_ff, rate_num_in;
   logic [32:0] rate_den_ff, rate_den_in;
   logic [13:0] rate_ff, rate_in;
   tlqm_pkg::rsp_type out_ff, out_in;
   logic        full_ff, full_in;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [tlqm_pkg::REC_W-1:0] wr_word, rd_word;
   logic        div_start, div_done;
   logic [63:0] div_a, div_q;
   logic [32:0] div_b;
   logic [32:0] exp33;
   logic [31:0] d, dm1;
   logic [32:0] s33;
   logic [64:0] s65;
   logic [47:0] iv, jt;
   logic [47:0] q48;

   assign rd_rec = tlqm_pkg::rec_type'(rd_word);
   assign rd_addr = wk_in.dev[AW-1:0];
   assign q48 = (div_q[63:48] != '0) ? '1 : div_q[47:0];

   tlqm_ram #(.WIDTH(tlqm_pkg::REC_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_word),
      .rd_addr(rd_addr), .rd_data(rd_word));

   tlqm_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q));

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      wk_in       = wk_ff;
      rec_in      = rec_ff;
      do_iv_in    = do_iv_ff;
      do_jt_in    = do_jt_ff;
      rate_num_in = rate_num_ff;
      rate_den_in = rate_den_ff;
      rate_in     = rate_ff;
      out_in      = out_ff;
      full_in     = full_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = wk_ff.dev[AW-1:0];
      wr_word     = rec_ff;
      div_start   = 1'b0;
      div_a       = '0;
      div_b       = '0;
      d = '0; dm1 = '0; s33 = '0; s65 = '0; iv = '0; jt = '0; exp33 = '0;
      if (full_ff && rsp_pop) full_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_word = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(RAM_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               wk_in = q_data;
               state_in = q_data.hit ? S_READ : S_DONE;
            end
         end
         S_READ: state_in = S_UPD;
         S_UPD: begin
            rec_in = rd_rec;
            rec_in.recv_total = (rd_rec.recv_total == '1) ? '1 : rd_rec.recv_total + 32'd1;
            if (!rd_rec.seq_valid) begin
               rec_in.seq_valid = 1'b1;
               rec_in.last_seq  = wk_ff.seq;
            end else begin
               d   = wk_ff.seq - rd_rec.last_seq;
               dm1 = d - 32'd1;
               if (d > 32'd1 && d < tlqm_pkg::HALF_RANGE) begin
                  s33 = {1'b0, rd_rec.miss_total} + {1'b0, dm1};
                  rec_in.miss_total = s33[32] ? '1 : s33[31:0];
                  rec_in.last_seq = wk_ff.seq;
               end else if (d == 32'd1) begin
                  rec_in.last_seq = wk_ff.seq;
               end else if (d >= tlqm_pkg::HALF_RANGE) begin
                  rec_in.ooo_total = (rd_rec.ooo_total == '1) ? '1 : rd_rec.ooo_total + 32'd1;
               end
            end
            do_iv_in = rd_rec.time_valid;
            do_jt_in = rd_rec.time_valid && rd_rec.prior_valid;
            if (rd_rec.time_valid) begin
               iv = (wk_ff.now > rd_rec.last_time) ? wk_ff.now - rd_rec.last_time : '0;
               rec_in.held_last = iv;
               s65 = {1'b0, rd_rec.interval_sum} + {17'd0, iv};
               rec_in.interval_sum = s65[64] ? '1 : s65[63:0];
               rec_in.interval_cnt = (rd_rec.interval_cnt == '1) ? '1
                                     : rd_rec.interval_cnt + 32'd1;
            end
            rec_in.last_time  = wk_ff.now;
            rec_in.time_valid = 1'b1;
            state_in = S_JIT;
         end
         S_JIT: begin
            // The new interval sits in held_last; prior_interval still holds
            // the one before it.
            if (do_jt_ff) begin
               jt = (rec_ff.held_last > rec_ff.prior_interval)
                    ? rec_ff.held_last - rec_ff.prior_interval
                    : rec_ff.prior_interval - rec_ff.held_last;
               s65 = {1'b0, rec_ff.jitter_sum} + {17'd0, jt};
               rec_in.jitter_sum = s65[64] ? '1 : s65[63:0];
               rec_in.jitter_cnt = (rec_ff.jitter_cnt == '1) ? '1
                                   : rec_ff.jitter_cnt + 32'd1;
            end
            if (do_iv_ff) begin
               rec_in.prior_interval = rec_ff.held_last;
               rec_in.prior_valid    = 1'b1;
            end
            state_in = S_DIV1;
         end
         S_DIV1: begin
            // Rate divisor: received plus missing, kept at its full 33 bits.
            exp33 = {1'b0, rec_ff.recv_total} + {1'b0, rec_ff.miss_total};
            rate_num_in = 64'(rec_ff.recv_total) * 64'(tlqm_pkg::RATE_SCALE);
            rate_den_in = exp33;
            if (do_iv_ff) begin
               div_start = 1'b1;
               div_a = rec_ff.interval_sum;
               div_b = {1'b0, rec_ff.interval_cnt};
               state_in = S_WAIT1;
            end else state_in = S_DIV3;
         end
         S_WAIT1: if (div_done) begin
            rec_in.held_avg_iv = q48;
            state_in = do_jt_ff ? S_DIV2 : S_DIV3;
         end
         S_DIV2: begin
            div_start = 1'b1;
            div_a = rec_ff.jitter_sum;
            div_b = {1'b0, rec_ff.jitter_cnt};
            state_in = S_WAIT2;
         end
         S_WAIT2: if (div_done) begin
            rec_in.held_avg_jt = q48;
            state_in = S_DIV3;
         end
         S_DIV3: begin
            div_start = 1'b1;
            div_a = rate_num_ff;
            div_b = rate_den_ff;
            state_in = S_WAIT3;
         end
         S_WAIT3: if (div_done) begin
            rate_in = div_q[13:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!full_in) begin
               out_in = '0;
               if (wk_ff.hit) begin
                  wr_en = 1'b1;
                  out_in.accepted            = 1'b1;
                  out_in.received_count      = rec_ff.recv_total;
                  out_in.missing_count       = rec_ff.miss_total;
                  out_in.out_of_order_count  = rec_ff.ooo_total;
                  out_in.last_interval_ms    = rec_ff.held_last;
                  out_in.average_interval_ms = rec_ff.held_avg_iv;
                  out_in.average_jitter_ms   = rec_ff.held_avg_jt;
                  out_in.delivery_rate       = rate_ff;
               end
               full_in  = 1'b1;
               state_in = S_HOLD;
            end
         end
         S_HOLD: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      wk_ff       <= wk_in;
      rec_ff      <= rec_in;
      do_iv_ff    <= do_iv_in;
      do_jt_ff    <= do_jt_in;
      rate_num_ff <= rate_num_in;
      rate_den_ff <= rate_den_in;
      rate_ff     <= rate_in;
      out_ff      <= out_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         full_ff  <= full_in;
      end
   end

   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset) (state_ff == S_CLEAR) |-> !q_pop)
      else $error("pop during clear");
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == S_DIV1 || state_ff == S_DIV2 || state_ff == S_DIV3))
      else $error("divider started outside a divide step");
   assert property (@(posedge clock) disable iff (reset) (state_ff == S_HOLD) |-> full_ff)
      else $error("result lost");
endmodule

// ----- rtl/telemetry_link_quality_monitor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_link_quality_monitor_core
// Per-device sequence gap and inter-arrival jitter monitor.
//
// Frames enter as a queue push on req_push/req_full with the payload on
// req_data; each push yields exactly one result, read from rsp_data while
// rsp_empty is low and taken by rsp_pop. The type slots and enable mask are
// written over the APB port at byte addresses 0, 4, 8, 12 and 16.
// The front stage matches the message type and parks the item in a
// two-entry queue, so new frames are taken while the back is busy.
// The back reads the device record from RAM, updates counters and sums,
// then runs up to three divisions on one shared bit-serial divider
// (average interval, average jitter, delivery rate). The back works one
// frame at a time, so that divider sets the frame rate. A device's first
// frame needs only the rate division, its second frame two divisions. A
// frame that is not counted goes straight from the queue to the result
// register and skips the record update and the divisions. After reset the
// device RAM is cleared one entry a cycle, over DEVICE_COUNT entries
// (rounded up to a power of two, at most 16), before frames are worked;
// pushes still fill the queue meanwhile. If the receiver stalls, the result
// holds in the output register, the back waits, and req_full rises once
// the queue has two items waiting.
// ----------------------------------------------------------------------------
module telemetry_link_quality_monitor_core #(
   parameter int DEVICE_COUNT = tlqm_pkg::DEVICE_COUNT_DEFAULT,
   parameter int TYPE_SLOTS   = tlqm_pkg::TYPE_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tlqm_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tlqm_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   // Classified items move from front to back through this queue.
   logic               q_valid, q_pop;
   tlqm_pkg::work_type q_data;

   assign pready = 1'b1;

   tlqm_front #(.DEVICE_COUNT(DEVICE_COUNT), .TYPE_SLOTS(TYPE_SLOTS)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .csr_psel(psel), .csr_penable(penable),
      .csr_pwrite(pwrite), .csr_paddr(paddr), .csr_pwdata(pwdata),
      .csr_prdata(prdata), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

   tlqm_back #(.DEVICE_COUNT(DEVICE_COUNT)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data));
endmodule
